// ----- hw/rtl/fwpa_pkg.sv -----
// Shared types, constants and pattern tables for the fullwidth punctuation filter.
`default_nettype none
package fwpa_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int WIN_LEN    = 3;

  typedef enum logic [1:0] {
    CLS_PASS  = 2'd0,
    CLS_GBK   = 2'd1,
    CLS_UTF8  = 2'd2,
    CLS_HKSCS = 2'd3
  } fwpa_cls_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } fwpa_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } fwpa_out_t;

  // Results of one input transfer: up to three bytes, in order.
  typedef struct packed {
    logic [WIN_LEN-1:0][7:0] bytes;
    logic [1:0]              cnt;
    logic                    last;
  } fwpa_grp_t;

  localparam logic [7:0] PAT [4][3][3] = '{
    '{ '{8'h00, 8'h00, 8'h00}, '{8'h00, 8'h00, 8'h00}, '{8'h00, 8'h00, 8'h00} },
    '{ '{8'ha1, 8'ha1, 8'h00}, '{8'ha3, 8'ha8, 8'h00}, '{8'ha3, 8'ha9, 8'h00} },
    '{ '{8'he3, 8'h80, 8'h80}, '{8'hef, 8'hbc, 8'h88}, '{8'hef, 8'hbc, 8'h89} },
    '{ '{8'ha1, 8'h40, 8'h00}, '{8'ha1, 8'h5d, 8'h00}, '{8'ha1, 8'h5e, 8'h00} }
  };

  localparam logic [7:0] REPL [3] = '{8'h20, 8'h28, 8'h29};

  localparam logic [2:0] PAT_LEN [4] = '{3'd1, 3'd2, 3'd3, 3'd2};

  function automatic fwpa_cls_t cls_of(input logic [7:0] id);
    fwpa_cls_t c;
    if (id inside {8'd28, 8'd87, 8'd248, 8'd249, [8'd216:8'd222]}) begin
      c = CLS_GBK;
    end else if (id inside {8'd45, 8'd46, 8'd63, 8'd255, [8'd224:8'd247]}) begin
      c = CLS_UTF8;
    end else if (id inside {8'd152, 8'd153}) begin
      c = CLS_HKSCS;
    end else begin
      c = CLS_PASS;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/fwpa_front.sv -----
// Front end: collation register, held bytes and pattern matching per input transfer.
`default_nettype none
module fwpa_front
  import fwpa_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  input  wire fwpa_in_t   in_data,
  input  wire logic       q_full,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  output fwpa_grp_t       grp,
  output logic            grp_push
);

  logic [7:0]       coll_r;
  logic [1:0][7:0]  pend_r, pend_nxt;
  logic [1:0]       pcnt_r, pcnt_nxt;
  logic             accept;
  fwpa_cls_t        cls;

  assign accept = in_push && !q_full;
  assign cls    = cls_of(coll_r);

  always_comb begin
    logic [WIN_LEN-1:0][7:0] win;
    logic [2:0] n, pos, rem, k, plen, idx;
    logic       stop, hit, eq;
    logic [1:0] hit_p;
    win      = '0;
    n        = 3'(pcnt_r) + 3'd1;
    pos      = '0;
    stop     = 1'b0;
    plen     = PAT_LEN[cls];
    rem      = '0;
    k        = '0;
    idx      = '0;
    hit      = 1'b0;
    eq       = 1'b0;
    hit_p    = '0;
    grp      = '0;
    grp.last = in_data.in_last;
    case (pcnt_r)
      2'd0: begin
        win[0] = in_data.in_byte;
      end
      2'd1: begin
        win[0] = pend_r[0];
        win[1] = in_data.in_byte;
      end
      default: begin
        win[0] = pend_r[0];
        win[1] = pend_r[1];
        win[2] = in_data.in_byte;
      end
    endcase
    for (int i = 0; i < WIN_LEN; i++) begin
      if (!stop && pos < n) begin
        rem   = n - pos;
        k     = (rem < plen) ? rem : plen;
        hit   = 1'b0;
        hit_p = '0;
        for (int p = 2; p >= 0; p--) begin
          eq = 1'b1;
          for (int j = 0; j < WIN_LEN; j++) begin
            idx = pos + 3'(j);
            if (3'(j) < k && PAT[cls][p][j] != win[idx[1:0]]) begin
              eq = 1'b0;
            end
          end
          if (eq) begin
            hit   = 1'b1;
            hit_p = 2'(p);
          end
        end
        if (cls == CLS_PASS) begin
          grp.bytes[grp.cnt] = win[pos[1:0]];
          grp.cnt            = grp.cnt + 2'd1;
          pos                = pos + 3'd1;
        end else if (rem >= plen && hit) begin
          grp.bytes[grp.cnt] = REPL[hit_p];
          grp.cnt            = grp.cnt + 2'd1;
          pos                = pos + plen;
        end else if (rem < plen && hit && !in_data.in_last) begin
          stop = 1'b1;
        end else begin
          grp.bytes[grp.cnt] = win[pos[1:0]];
          grp.cnt            = grp.cnt + 2'd1;
          pos                = pos + 3'd1;
        end
      end
    end
    pend_nxt = '0;
    pcnt_nxt = '0;
    if (!in_data.in_last) begin
      rem      = n - pos;
      pcnt_nxt = rem[1:0];
      idx      = pos;
      pend_nxt[0] = win[idx[1:0]];
      idx      = pos + 3'd1;
      pend_nxt[1] = win[idx[1:0]];
    end
  end

  assign grp_push = accept && (grp.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coll_r <= '0;
      pcnt_r <= '0;
    end else begin
      if (cfg_we) begin
        coll_r <= cfg_wdata;
      end
      if (accept) begin
        pcnt_r <= pcnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_r <= pend_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/fwpa_fifo.sv -----
// Short queue of result groups between the front end and the output stage.
`default_nettype none
module fwpa_fifo
  import fwpa_pkg::*;
#(
  parameter int Depth = FIFO_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire fwpa_grp_t wdata,
  input  wire logic      pop,
  output fwpa_grp_t      rdata,
  output logic           not_empty,
  output logic           full
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  fwpa_grp_t       mem_r [Depth];
  logic [PtrW-1:0] wptr_r, rptr_r;
  logic [CntW-1:0] cnt_r;

  assign rdata     = mem_r[rptr_r];
  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == CntW'(Depth));

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PtrW'(Depth - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == PtrW'(Depth - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/fwpa_back.sv -----
// Output stage: unpacks result groups into single byte transfers.
`default_nettype none
module fwpa_back
  import fwpa_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire fwpa_grp_t q_data,
  input  wire logic      q_valid,
  output logic           q_pop,
  input  wire logic      out_pop,
  output logic           out_empty,
  output fwpa_out_t      out_data
);

  fwpa_grp_t  cur_r;
  logic       vld_r;
  logic [1:0] idx_r;
  logic       fire, at_end, finish;

  assign fire      = out_pop && vld_r;
  assign at_end    = (idx_r == cur_r.cnt - 2'd1);
  assign finish    = fire && at_end;
  assign q_pop     = q_valid && (!vld_r || finish);
  assign out_empty = !vld_r;

  assign out_data.out_byte = cur_r.bytes[idx_r];
  assign out_data.out_last = cur_r.last && at_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else if (q_pop) begin
      vld_r <= 1'b1;
      idx_r <= '0;
    end else if (finish) begin
      vld_r <= 1'b0;
    end else if (fire) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/fullwidth_punct_to_ascii_filter_unit.sv -----
// Path: the results of an input transfer pass the group queue and the output register to the
// out ports, unless held waiting for the next byte of a possible multi-byte pattern.
// Throughput: one input per cycle while in_full is low, one output transfer per cycle; one
// input may yield up to three output bytes, queued in a FifoDepth-entry group queue.
// Reset: synchronous active-low rst_n empties the queue and held bytes, collation reads 0.
`default_nettype none
module fullwidth_punct_to_ascii_filter_unit
  import fwpa_pkg::*;
#(
  parameter int FifoDepth = FIFO_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire fwpa_in_t   in_data,
  output logic            out_empty,
  input  wire logic       out_pop,
  output fwpa_out_t       out_data,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  fwpa_grp_t grp, q_data;
  logic      grp_push, q_full, q_valid, q_pop;

  assign in_full = q_full;

  fwpa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .q_full    (q_full),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .grp       (grp),
    .grp_push  (grp_push)
  );

  fwpa_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (grp_push),
    .wdata     (grp),
    .pop       (q_pop),
    .rdata     (q_data),
    .not_empty (q_valid),
    .full      (q_full)
  );

  fwpa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_data),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- sim/tb_fullwidth_punct_to_ascii_filter_unit.sv -----
// Self-checking testbench for the fullwidth punctuation to ASCII filter unit.
`default_nettype none
module tb_fullwidth_punct_to_ascii_filter_unit
  import fwpa_pkg::*;
();

  localparam logic [7:0] ID_PASS  = 8'd0;
  localparam logic [7:0] ID_GBK   = 8'd28;
  localparam logic [7:0] ID_UTF8  = 8'd255;
  localparam logic [7:0] ID_HKSCS = 8'd152;

  localparam logic [7:0] ID_CHOICES [15] = '{
    8'd0, 8'd255, 8'd28, 8'd87, 8'd248, 8'd249, 8'd216, 8'd222,
    8'd45, 8'd46, 8'd63, 8'd224, 8'd247, 8'd152, 8'd153
  };

  // Multi-byte sequences per family (GBK, UTF-8, HKSCS) and their ASCII stand-ins.
  localparam logic [7:0] FW_SEQ [3][3][3] = '{
    '{ '{8'ha1, 8'ha1, 8'h00}, '{8'ha3, 8'ha8, 8'h00}, '{8'ha3, 8'ha9, 8'h00} },
    '{ '{8'he3, 8'h80, 8'h80}, '{8'hef, 8'hbc, 8'h88}, '{8'hef, 8'hbc, 8'h89} },
    '{ '{8'ha1, 8'h40, 8'h00}, '{8'ha1, 8'h5d, 8'h00}, '{8'ha1, 8'h5e, 8'h00} }
  };
  localparam logic [7:0] ASCII_SUB [3] = '{8'h20, 8'h28, 8'h29};

  localparam int SETTLE_CYCLES = 6;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  fwpa_in_t  in_data;
  logic      out_empty;
  logic      out_pop;
  fwpa_out_t out_data;
  logic      cfg_we;
  logic [7:0] cfg_wdata;

  fwpa_out_t  awaited_bytes [$];
  logic [7:0] cur_collation;
  logic [7:0] held_bytes [2];
  int         held_count;

  int errors;
  int items_sent;
  int bytes_checked;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;

  fullwidth_punct_to_ascii_filter_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic fwpa_cls_t collation_class(input logic [7:0] id);
    if (id == 8'd28 || id == 8'd87 || id == 8'd248 || id == 8'd249 ||
        (id >= 8'd216 && id <= 8'd222)) begin
      return CLS_GBK;
    end
    if (id == 8'd45 || id == 8'd46 || id == 8'd63 || id == 8'd255 ||
        (id >= 8'd224 && id <= 8'd247)) begin
      return CLS_UTF8;
    end
    if (id == 8'd152 || id == 8'd153) begin
      return CLS_HKSCS;
    end
    return CLS_PASS;
  endfunction

  function automatic int seq_len(input fwpa_cls_t cls);
    case (cls)
      CLS_GBK:   return 2;
      CLS_UTF8:  return 3;
      CLS_HKSCS: return 2;
      default:   return 1;
    endcase
  endfunction

  // Index of the first sequence whose first k bytes equal win[pos +: k], or -1.
  function automatic int seq_prefix_hit(input fwpa_cls_t cls, input logic [7:0] win [3],
                                        input int pos, input int k);
    int  row;
    bit  same;
    row = int'(cls) - 1;
    for (int p = 0; p < 3; p++) begin
      same = 1'b1;
      for (int j = 0; j < k; j++) begin
        if (FW_SEQ[row][p][j] != win[pos + j]) begin
          same = 1'b0;
        end
      end
      if (same) begin
        return p;
      end
    end
    return -1;
  endfunction

  function automatic void predict_filtered_bytes(input logic [7:0] b, input logic last);
    logic [7:0] win [3];
    fwpa_out_t  res [$];
    fwpa_out_t  r;
    fwpa_cls_t  cls;
    int n, pos, rem, plen, k, hit, j;
    win[0] = held_bytes[0];
    win[1] = held_bytes[1];
    win[2] = 8'h00;
    n = held_count;
    win[n] = b;
    n++;
    cls = collation_class(cur_collation);
    plen = seq_len(cls);
    pos = 0;
    while (pos < n && res.size() < 3) begin
      rem = n - pos;
      k = (rem < plen) ? rem : plen;
      hit = (cls == CLS_PASS) ? -1 : seq_prefix_hit(cls, win, pos, k);
      if (rem >= plen && hit >= 0) begin
        r.out_byte = ASCII_SUB[hit];
        r.out_last = 1'b0;
        res.push_back(r);
        pos += plen;
      end else if (hit >= 0 && !last) begin
        break;
      end else begin
        r.out_byte = win[pos];
        r.out_last = 1'b0;
        res.push_back(r);
        pos++;
      end
    end
    held_bytes[0] = 8'h00;
    held_bytes[1] = 8'h00;
    held_count = 0;
    if (!last) begin
      for (j = 0; pos + j < n && j < 2; j++) begin
        held_bytes[j] = win[pos + j];
      end
      held_count = j;
    end else if (res.size() > 0) begin
      res[res.size() - 1].out_last = 1'b1;
    end
    foreach (res[i]) begin
      awaited_bytes.push_back(res[i]);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    in_data <= '{b, last};
    in_push <= 1'b1;
    do begin
      @(posedge clk);
    end while (in_full);
    items_sent++;
    predict_filtered_bytes(b, last);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic settle_output();
    in_push <= 1'b0;
    while (awaited_bytes.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_collation(input logic [7:0] id);
    settle_output();
    cfg_wdata <= id;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_collation = id;
  endtask

  task automatic send_bytes(input logic [7:0] seq [$], input bit terminate);
    foreach (seq[i]) begin
      send_byte(seq[i], terminate && (i == seq.size() - 1));
    end
  endtask

  function automatic void append_token(ref logic [7:0] q [$], input fwpa_cls_t cls);
    int kind, row, p, len, cut;
    kind = $urandom_range(0, 99);
    row = (cls == CLS_PASS) ? $urandom_range(0, 2) : int'(cls) - 1;
    if (kind >= 40) begin
      row = $urandom_range(0, 2);
    end
    p = $urandom_range(0, 2);
    len = (row == 1) ? 3 : 2;
    if (kind < 55) begin
      for (int j = 0; j < len; j++) begin
        q.push_back(FW_SEQ[row][p][j]);
      end
    end else if (kind < 70) begin
      cut = $urandom_range(1, len - 1);
      for (int j = 0; j < cut; j++) begin
        q.push_back(FW_SEQ[row][p][j]);
      end
    end else if (kind < 80) begin
      q.push_back($urandom_range(0, 1) ? 8'hff : 8'h00);
    end else begin
      q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic send_random_string(input bit terminate);
    logic [7:0] q [$];
    fwpa_cls_t  cls;
    cls = collation_class(cur_collation);
    repeat ($urandom_range(1, 5)) append_token(q, cls);
    send_bytes(q, terminate);
  endtask

  task automatic run_random_phase(input int count);
    int start;
    int r;
    r = $urandom_range(0, 15);
    write_collation((r == 15) ? 8'($urandom_range(0, 255)) : ID_CHOICES[r]);
    start = items_sent;
    while (items_sent - start < count) begin
      if ($urandom_range(0, 9) == 0) begin
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        send_random_string(1'b1);
      end
    end
    // Leave a string open so the next collation judges the held bytes.
    if ($urandom_range(0, 1)) begin
      send_random_string(1'b0);
    end
  endtask

  task automatic test_reset_passthrough();
    send_bytes('{8'ha1, 8'h00, 8'hff}, 1'b1);
  endtask

  task automatic test_gbk_patterns();
    write_collation(ID_GBK);
    send_bytes('{8'ha1, 8'ha1, 8'ha3, 8'ha8, 8'ha1, 8'ha3, 8'ha9, 8'ha3}, 1'b1);
  endtask

  task automatic test_utf8_patterns();
    write_collation(ID_UTF8);
    send_bytes('{8'he3, 8'h80, 8'h80, 8'hef, 8'hbc, 8'h89, 8'hef, 8'hbc, 8'h41}, 1'b1);
  endtask

  task automatic test_hkscs_patterns();
    write_collation(ID_HKSCS);
    send_bytes('{8'ha1, 8'h40, 8'ha1, 8'h5e}, 1'b1);
  endtask

  task automatic test_collation_switch();
    write_collation(ID_GBK);
    send_byte(8'ha1, 1'b0);
    write_collation(ID_PASS);
    send_byte(8'ha1, 1'b1);
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 15;
    recv_idle_pct = 70;
    repeat (2) run_random_phase(22);
    send_idle_pct = 70;
    recv_idle_pct = 15;
    repeat (2) run_random_phase(22);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (2) run_random_phase(22);
  endtask

  task automatic test_backpressure();
    int start;
    write_collation(ID_UTF8);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 60;
    start = items_sent;
    while (items_sent - start < 24) begin
      send_random_string(1'b1);
    end
  endtask

  // Check each output transfer against the oldest predicted byte; pick the next pop.
  initial begin
    out_pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        if (awaited_bytes.size() == 0) begin
          $error("unexpected output transfer: out_byte %h out_last %b",
                 out_data.out_byte, out_data.out_last);
          errors++;
        end else begin
          fwpa_out_t e;
          e = awaited_bytes.pop_front();
          bytes_checked++;
          if (out_data.out_byte !== e.out_byte) begin
            $error("out_byte mismatch: expected %h, got %h", e.out_byte, out_data.out_byte);
            errors++;
          end
          if (out_data.out_last !== e.out_last) begin
            $error("out_last mismatch: expected %b, got %b", e.out_last, out_data.out_last);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #1000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    errors = 0;
    items_sent = 0;
    bytes_checked = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 0;
    cur_collation = ID_PASS;
    held_bytes[0] = 8'h00;
    held_bytes[1] = 8'h00;
    held_count = 0;
    rst_n <= 1'b0;
    in_push <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= 8'h00;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_passthrough();
    test_gbk_patterns();
    test_utf8_patterns();
    test_hkscs_patterns();
    test_collation_switch();
    test_random_traffic();
    test_backpressure();
    settle_output();

    $display("Run covered %0d input transfers and %0d output transfers", items_sent,
             bytes_checked);
    $display("over passthrough, GBK, UTF-8 and HKSCS ids, mid-string switches and a full stall");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
